// ----- rtl/core/cled_pkg.sv -----
// shared types, status codes and lookup functions for the character literal decoder
package cled_pkg;

  localparam int CharW   = 8;
  localparam int StatusW = 4;
  localparam int CountW  = 2;

  localparam logic [CountW-1:0] MaxOctDigits = 2'd3;

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_PLAIN    = 3'd1,
    PH_ESC      = 3'd2,
    PH_CLASSIC  = 3'd3,
    PH_HEXSTART = 3'd4,
    PH_HEXDIG   = 3'd5,
    PH_OCTAL    = 3'd6,
    PH_ERROR    = 3'd7
  } phase_t;

  localparam logic [StatusW-1:0] ST_OK          = 4'd0;
  localparam logic [StatusW-1:0] ST_EMPTY       = 4'd1;
  localparam logic [StatusW-1:0] ST_MULTICHAR   = 4'd2;
  localparam logic [StatusW-1:0] ST_INCOMPLETE  = 4'd3;
  localparam logic [StatusW-1:0] ST_NO_HEX      = 4'd4;
  localparam logic [StatusW-1:0] ST_BAD_HEX     = 4'd5;
  localparam logic [StatusW-1:0] ST_HEX_TRAIL   = 4'd6;
  localparam logic [StatusW-1:0] ST_OCT_TRAIL   = 4'd7;
  localparam logic [StatusW-1:0] ST_UNSUPPORTED = 4'd8;

  localparam logic [CharW-1:0] CharBackslash = 8'h5c;
  localparam logic [CharW-1:0] CharX         = 8'h78;
  localparam logic [CharW-1:0] CharZero      = 8'h30;
  localparam logic [CharW-1:0] CharSeven     = 8'h37;

  typedef struct packed {
    phase_t              phase;
    logic [CharW-1:0]    value_acc;
    logic [CountW-1:0]   digit_count;
    logic [StatusW-1:0]  status_latch;
  } dec_state_t;

  typedef struct packed {
    logic                valid;
    logic [CharW-1:0]    value;
    logic [StatusW-1:0]  status;
  } dec_result_t;

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_value(input logic [CharW-1:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
    return v;
  endfunction

  // bit 8 set means not a classic escape
  function automatic logic [8:0] classic_value(input logic [CharW-1:0] c);
    logic [8:0] v;
    case (c)
      8'h6e:   v = 9'd10;
      8'h74:   v = 9'd9;
      8'h72:   v = 9'd13;
      8'h5c:   v = 9'd92;
      8'h27:   v = 9'd39;
      8'h22:   v = 9'd34;
      8'h61:   v = 9'd7;
      8'h62:   v = 9'd8;
      8'h66:   v = 9'd12;
      8'h76:   v = 9'd11;
      default: v = 9'h100;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/cled_step.sv -----
// next-state and result logic for one byte of a character literal
module cled_step (
  input  cled_pkg::dec_state_t         state_i,
  input  logic [cled_pkg::CharW-1:0]   char_byte,
  input  logic                         char_present,
  input  logic                         last_byte,
  output cled_pkg::dec_state_t         state_o,
  output cled_pkg::dec_result_t        result_o
);

  cled_pkg::dec_state_t taken;
  logic [8:0]           cls;
  logic [4:0]           hx;
  logic                 is_oct;

  assign cls    = cled_pkg::classic_value(char_byte);
  assign hx     = cled_pkg::hex_value(char_byte);
  assign is_oct = (char_byte >= cled_pkg::CharZero) && (char_byte <= cled_pkg::CharSeven);

  always_comb begin
    taken = state_i;
    if (char_present) begin
      case (state_i.phase)
        cled_pkg::PH_START: begin
          if (char_byte == cled_pkg::CharBackslash) begin
            taken.phase = cled_pkg::PH_ESC;
          end else begin
            taken.phase     = cled_pkg::PH_PLAIN;
            taken.value_acc = char_byte;
          end
        end
        cled_pkg::PH_PLAIN: begin
          taken.phase        = cled_pkg::PH_ERROR;
          taken.status_latch = cled_pkg::ST_MULTICHAR;
          taken.value_acc    = '0;
        end
        cled_pkg::PH_ESC: begin
          if (!cls[8]) begin
            taken.phase     = cled_pkg::PH_CLASSIC;
            taken.value_acc = cls[7:0];
          end else if (char_byte == cled_pkg::CharX) begin
            taken.phase     = cled_pkg::PH_HEXSTART;
            taken.value_acc = '0;
          end else if (is_oct) begin
            taken.phase       = cled_pkg::PH_OCTAL;
            taken.value_acc   = {5'd0, char_byte[2:0]};
            taken.digit_count = 2'd1;
          end else begin
            taken.phase        = cled_pkg::PH_ERROR;
            taken.status_latch = cled_pkg::ST_UNSUPPORTED;
            taken.value_acc    = '0;
          end
        end
        cled_pkg::PH_HEXSTART, cled_pkg::PH_HEXDIG: begin
          if (!hx[4]) begin
            taken.value_acc = {state_i.value_acc[3:0], hx[3:0]};
            taken.phase     = cled_pkg::PH_HEXDIG;
          end else begin
            taken.phase        = cled_pkg::PH_ERROR;
            taken.status_latch = (state_i.phase == cled_pkg::PH_HEXSTART) ?
                                 cled_pkg::ST_BAD_HEX : cled_pkg::ST_HEX_TRAIL;
            taken.value_acc    = '0;
          end
        end
        cled_pkg::PH_OCTAL: begin
          if (state_i.digit_count < cled_pkg::MaxOctDigits && is_oct) begin
            // shift drops the top bits, which is the 8-bit mask
            taken.value_acc   = {state_i.value_acc[4:0], char_byte[2:0]};
            taken.digit_count = state_i.digit_count + 2'd1;
          end else begin
            taken.phase        = cled_pkg::PH_ERROR;
            taken.status_latch = cled_pkg::ST_OCT_TRAIL;
            taken.value_acc    = '0;
          end
        end
        default: begin
          // classic escape and error phases ignore further bytes
        end
      endcase
    end
  end

  always_comb begin
    result_o.valid  = last_byte;
    result_o.value  = '0;
    case (taken.phase)
      cled_pkg::PH_START:    result_o.status = cled_pkg::ST_EMPTY;
      cled_pkg::PH_ESC:      result_o.status = cled_pkg::ST_INCOMPLETE;
      cled_pkg::PH_HEXSTART: result_o.status = cled_pkg::ST_NO_HEX;
      cled_pkg::PH_ERROR:    result_o.status = taken.status_latch;
      default: begin
        result_o.status = cled_pkg::ST_OK;
        result_o.value  = taken.value_acc;
      end
    endcase
  end

  always_comb begin
    if (last_byte) begin
      state_o.phase        = cled_pkg::PH_START;
      state_o.value_acc    = '0;
      state_o.digit_count  = '0;
      state_o.status_latch = cled_pkg::ST_OK;
    end else begin
      state_o = taken;
    end
  end

endmodule

// ----- rtl/core/char_literal_escape_decoder_unit.sv -----
// top level of the character literal escape decoder with stream ports
//
//   channel  | dir | tdata                          | tuser        | tlast
//   in_      | in  | [7:0] char_byte                | char_present | last_byte
//   out_     | out | [7:0] decoded_value,[11:8] st  | -            | -
//
// one input transaction per cycle while in_tready is high; the result of a final
// byte appears on out_ the cycle after it is accepted, from the result register
// rst_n (synchronous) returns the literal state to its start and empties out_
// in_tready drops only while a result waits in the output register and
// out_tready is low
module char_literal_escape_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tuser,   // char_present
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [7:0] decoded_value, [11:8] status_code, [15:12] zero
);

  cled_pkg::dec_state_t  state_r;
  cled_pkg::dec_state_t  state_nxt;
  cled_pkg::dec_result_t result;
  logic                  in_fire;
  logic                  out_valid_r;
  logic [cled_pkg::CharW-1:0]   out_value_r;
  logic [cled_pkg::StatusW-1:0] out_status_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  cled_step u_step (
    .state_i      (state_r),
    .char_byte    (in_tdata),
    .char_present (in_tuser),
    .last_byte    (in_tlast),
    .state_o      (state_nxt),
    .result_o     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase        <= cled_pkg::PH_START;
      state_r.value_acc    <= '0;
      state_r.digit_count  <= '0;
      state_r.status_latch <= cled_pkg::ST_OK;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && result.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && result.valid) begin
      out_value_r  <= result.value;
      out_status_r <= result.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_status_r, out_value_r};

  // a final byte always leaves the decoder at the start of a literal
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> state_r.phase == cled_pkg::PH_START)
    else $error("state not cleared after final byte");

  // the latched code is only meaningful in the error phase
  a_latch_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase != cled_pkg::PH_ERROR |-> state_r.status_latch == cled_pkg::ST_OK)
    else $error("status latch set outside error phase");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != cled_pkg::ST_OK |-> out_value_r == '0)
    else $error("nonzero value with error status");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_status_r <= cled_pkg::ST_UNSUPPORTED)
    else $error("status code out of range");

  // a pending result is not overwritten while stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !in_fire)
    else $error("input taken over a stalled result");

endmodule

// ----- tb/tb_char_literal_escape_decoder_unit.sv -----
// self-checking stream testbench for the character literal escape decoder
module tb_char_literal_escape_decoder_unit;

  localparam int ItemGoal  = 1150;
  localparam int QuietLimit = 3000;

  typedef struct packed {
    logic [cled_pkg::CharW-1:0] ch;
    logic                       present;
    logic                       last;
    logic                       hold;
  } lit_item_t;

  typedef struct packed {
    logic [cled_pkg::CharW-1:0]   value;
    logic [cled_pkg::StatusW-1:0] status;
  } char_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  char_literal_escape_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  lit_item_t                  lit_items[$];
  char_result_t               expected_chars[$];
  logic [cled_pkg::CharW-1:0] body[$];

  // decoder state kept by the testbench
  cled_pkg::phase_t             lit_phase = cled_pkg::PH_START;
  logic [cled_pkg::CharW-1:0]   lit_acc = '0;
  logic [cled_pkg::CountW-1:0]  lit_digits = '0;
  logic [cled_pkg::StatusW-1:0] lit_status = cled_pkg::ST_OK;

  bit hold_next = 1'b0;
  bit sprinkle = 1'b0;
  bit in_took = 1'b0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  int item_total = 0;
  int in_gap = 0;
  int out_gap = 0;
  int quiet_cycles = 0;
  int err_cnt = 0;
  int in_count = 0;
  int lits_checked = 0;
  int status_hits[16];

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [4:0] hex_nibble(input logic [cled_pkg::CharW-1:0] c);
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
    return 5'h10;
  endfunction

  // msb set when the byte is not one of the ten simple escapes
  function automatic logic [8:0] simple_escape(input logic [cled_pkg::CharW-1:0] c);
    case (c)
      "n":     return 9'd10;
      "t":     return 9'd9;
      "r":     return 9'd13;
      "\\":    return 9'd92;
      "'":     return 9'd39;
      "\"":    return 9'd34;
      "a":     return 9'd7;
      "b":     return 9'd8;
      "f":     return 9'd12;
      "v":     return 9'd11;
      default: return 9'h100;
    endcase
  endfunction

  function automatic logic [cled_pkg::CharW-1:0] escape_letter(input int k);
    case (k)
      0:       return "n";
      1:       return "t";
      2:       return "r";
      3:       return "\\";
      4:       return "'";
      5:       return "\"";
      6:       return "a";
      7:       return "b";
      8:       return "f";
      default: return "v";
    endcase
  endfunction

  function automatic logic [cled_pkg::CharW-1:0] rand_hex_char();
    int d;
    d = $urandom_range(0, 21);
    if (d < 10) return 8'(8'h30 + d);
    if (d < 16) return 8'(8'h61 + d - 10);
    return 8'(8'h41 + d - 16);
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic flag_error(input logic [cled_pkg::StatusW-1:0] code);
    lit_phase  = cled_pkg::PH_ERROR;
    lit_status = code;
    lit_acc    = '0;
  endtask

  // advance the literal state by one accepted transaction
  task automatic decode_item(input logic [cled_pkg::CharW-1:0] c, input logic present,
                             input logic last);
    logic [4:0]   hv;
    logic [8:0]   ev;
    char_result_t r;
    if (present) begin
      case (lit_phase)
        cled_pkg::PH_START: begin
          if (c == cled_pkg::CharBackslash) begin
            lit_phase = cled_pkg::PH_ESC;
          end else begin
            lit_phase = cled_pkg::PH_PLAIN;
            lit_acc   = c;
          end
        end
        cled_pkg::PH_PLAIN: flag_error(cled_pkg::ST_MULTICHAR);
        cled_pkg::PH_ESC: begin
          ev = simple_escape(c);
          if (!ev[8]) begin
            lit_phase = cled_pkg::PH_CLASSIC;
            lit_acc   = ev[7:0];
          end else if (c == cled_pkg::CharX) begin
            lit_phase = cled_pkg::PH_HEXSTART;
            lit_acc   = '0;
          end else if (c >= cled_pkg::CharZero && c <= cled_pkg::CharSeven) begin
            lit_phase  = cled_pkg::PH_OCTAL;
            lit_acc    = c - cled_pkg::CharZero;
            lit_digits = 2'd1;
          end else begin
            flag_error(cled_pkg::ST_UNSUPPORTED);
          end
        end
        cled_pkg::PH_HEXSTART, cled_pkg::PH_HEXDIG: begin
          hv = hex_nibble(c);
          if (!hv[4]) begin
            lit_acc   = {lit_acc[3:0], hv[3:0]};
            lit_phase = cled_pkg::PH_HEXDIG;
          end else begin
            flag_error(lit_phase == cled_pkg::PH_HEXSTART ?
                       cled_pkg::ST_BAD_HEX : cled_pkg::ST_HEX_TRAIL);
          end
        end
        cled_pkg::PH_OCTAL: begin
          if (lit_digits < cled_pkg::MaxOctDigits &&
              c >= cled_pkg::CharZero && c <= cled_pkg::CharSeven) begin
            lit_acc    = {lit_acc[4:0], 3'(c - cled_pkg::CharZero)};
            lit_digits = lit_digits + 2'd1;
          end else begin
            flag_error(cled_pkg::ST_OCT_TRAIL);
          end
        end
        default: ;
      endcase
    end
    if (last) begin
      r.value = '0;
      case (lit_phase)
        cled_pkg::PH_START:    r.status = cled_pkg::ST_EMPTY;
        cled_pkg::PH_ESC:      r.status = cled_pkg::ST_INCOMPLETE;
        cled_pkg::PH_HEXSTART: r.status = cled_pkg::ST_NO_HEX;
        cled_pkg::PH_ERROR:    r.status = lit_status;
        default: begin
          r.status = cled_pkg::ST_OK;
          r.value  = lit_acc;
        end
      endcase
      expected_chars.push_back(r);
      lit_phase  = cled_pkg::PH_START;
      lit_acc    = '0;
      lit_digits = '0;
      lit_status = cled_pkg::ST_OK;
    end
  endtask

  task automatic push_item(input logic [cled_pkg::CharW-1:0] ch, input logic present,
                           input logic last);
    lit_item_t it;
    it.ch      = ch;
    it.present = present;
    it.last    = last;
    it.hold    = hold_next;
    hold_next  = 1'b0;
    lit_items.push_back(it);
    if (present || last) item_total++;
  endtask

  // queue the bytes in body as one literal, optionally closed by a bare last
  task automatic emit_literal(input bit end_bare);
    int n;
    n = body.size();
    if (n == 0) end_bare = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (sprinkle && $urandom_range(0, 19) == 0)
        push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      push_item(body[i], 1'b1, (i == n - 1) && !end_bare);
    end
    if (end_bare) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    body.delete();
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    lit_item_t it;
    logic      nv;
    logic      nr;
    if (rst_n) begin
      nv = in_tvalid;
      if (!in_tvalid || in_took) begin
        in_took = 1'b0;
        nv = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
        end else if (lit_items.size() != 0 &&
                     !(lit_items[0].hold && expected_chars.size() != 0)) begin
          it = lit_items.pop_front();
          in_tdata <= it.ch;
          in_tuser <= it.present;
          in_tlast <= it.last;
          nv = 1'b1;
          if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
          in_gap = pick_gap(in_calm);
        end
      end
      in_tvalid <= nv;

      if (out_gap > 0) begin
        nr = 1'b0;
        out_gap--;
      end else begin
        nr = 1'b1;
        if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
        if ($urandom_range(0, 5) == 0) out_gap = pick_gap(out_calm);
      end
      out_tready <= nr;
    end
  end

  // monitor, checker and watchdog: sampled on the rising edge
  always @(posedge clk) begin
    char_result_t want;
    bit           moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_tvalid && in_tready) begin
        decode_item(in_tdata, in_tuser, in_tlast);
        in_took = 1'b1;
        in_count++;
        moved = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        if (expected_chars.size() == 0) begin
          $error("unexpected result transaction, out_tdata = %h", out_tdata);
          err_cnt++;
        end else begin
          want = expected_chars.pop_front();
          lits_checked++;
          status_hits[want.status]++;
          if (out_tdata[7:0] !== want.value) begin
            $error("decoded_value: expected %0d, got %0d", want.value, out_tdata[7:0]);
            err_cnt++;
          end
          if (out_tdata[11:8] !== want.status) begin
            $error("status_code: expected %0d, got %0d", want.status, out_tdata[11:8]);
            err_cnt++;
          end
          if (out_tdata[15:12] !== 4'h0) begin
            $error("pad bits: expected 0, got %0d", out_tdata[15:12]);
            err_cnt++;
          end
        end
      end
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("no transaction for %0d cycles", QuietLimit);
        $display("char_literal_escape_decoder_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    int kind;
    int n;
    int next_hold;

    // directed literals
    body = '{8'h00};
    emit_literal(1'b1);
    body = '{8'hff};
    emit_literal(1'b0);
    push_item(8'h5a, 1'b0, 1'b0);
    body = '{8'h00, cled_pkg::CharBackslash};
    emit_literal(1'b0);
    body = '{cled_pkg::CharBackslash};
    emit_literal(1'b0);
    body = '{cled_pkg::CharBackslash, cled_pkg::CharX};
    emit_literal(1'b1);
    body = '{cled_pkg::CharBackslash, cled_pkg::CharX, "g"};
    emit_literal(1'b0);
    body = '{cled_pkg::CharBackslash, cled_pkg::CharX, "F", "z"};
    emit_literal(1'b0);
    body = '{cled_pkg::CharBackslash, "7", "7", "7"};
    emit_literal(1'b0);
    body = '{cled_pkg::CharBackslash, "1", "2", "3", "4"};
    emit_literal(1'b0);
    body = '{cled_pkg::CharBackslash, "8"};
    emit_literal(1'b0);
    body = '{cled_pkg::CharBackslash, "n", "9"};
    emit_literal(1'b0);

    // random literals, mostly well formed
    sprinkle  = 1'b1;
    next_hold = item_total;
    while (item_total < ItemGoal) begin
      if (item_total >= next_hold) begin
        hold_next = 1'b1;
        next_hold = next_hold + 150 + $urandom_range(0, 100);
      end
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        body.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 35) begin
        body.push_back(cled_pkg::CharBackslash);
        body.push_back(escape_letter($urandom_range(0, 9)));
        if ($urandom_range(0, 3) == 0) begin
          n = $urandom_range(1, 2);
          repeat (n) body.push_back(8'($urandom_range(0, 255)));
        end
      end else if (kind < 55) begin
        body.push_back(cled_pkg::CharBackslash);
        body.push_back(cled_pkg::CharX);
        n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
        repeat (n) body.push_back(rand_hex_char());
        if ($urandom_range(0, 6) == 0) body.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 72) begin
        body.push_back(cled_pkg::CharBackslash);
        n = $urandom_range(1, 4);
        repeat (n) body.push_back(8'(cled_pkg::CharZero + $urandom_range(0, 7)));
        if ($urandom_range(0, 6) == 0) body.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 80) begin
        n = $urandom_range(2, 4);
        repeat (n) body.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 85) begin
        // empty literal
      end else if (kind < 90) begin
        body.push_back(cled_pkg::CharBackslash);
        body.push_back(8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) body.push_back(8'($urandom_range(0, 255)));
      end
      emit_literal($urandom_range(0, 9) == 0);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (lit_items.size() != 0 || in_tvalid || expected_chars.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d input transactions, %0d literals checked", in_count, lits_checked);
    $display("status ok %0d empty %0d multi %0d incompl %0d nohex %0d badhex %0d %s",
             status_hits[cled_pkg::ST_OK], status_hits[cled_pkg::ST_EMPTY],
             status_hits[cled_pkg::ST_MULTICHAR], status_hits[cled_pkg::ST_INCOMPLETE],
             status_hits[cled_pkg::ST_NO_HEX], status_hits[cled_pkg::ST_BAD_HEX],
             $sformatf("hextrail %0d octtrail %0d unsupp %0d",
                       status_hits[cled_pkg::ST_HEX_TRAIL],
                       status_hits[cled_pkg::ST_OCT_TRAIL],
                       status_hits[cled_pkg::ST_UNSUPPORTED]));
    if (err_cnt == 0) begin
      $display("char_literal_escape_decoder_unit test passed");
    end else begin
      $display("char_literal_escape_decoder_unit test failed");
    end
    $finish;
  end

endmodule
